// ===== rtl/core/lpcp_pkg.sv =====
// ----------------------------------------------------------------------------
// lpcp_pkg
// Shared types and constants of the point projection pipeline.
// ----------------------------------------------------------------------------
package lpcp_pkg;

    localparam int CoefFracBits  = 20;
    localparam int PointFracBits = 16;
    localparam int CoefCount     = 24;
    localparam int WorldBase     = 12;
    localparam int QuoBits       = 12;

    localparam logic [11:0] WidthReset  = 12'd1242;
    localparam logic [11:0] HeightReset = 12'd375;

    localparam logic       CmdLoad  = 1'b0;
    localparam logic       CmdPoint = 1'b1;

    localparam logic [1:0] RegWidth  = 2'd0;
    localparam logic [1:0] RegHeight = 2'd1;

    typedef logic signed [31:0] t_coef;
    typedef logic signed [63:0] t_sum;

    typedef struct packed {
        logic [63:0]        rem;
        logic [63:0]        den;
        logic [QuoBits-1:0] quo;
    } t_div_lane;

endpackage

// ===== rtl/core/lpcp_coef_table.sv =====
// ----------------------------------------------------------------------------
// lpcp_coef_table
// Coefficient store for the projection and world matrices.
// ----------------------------------------------------------------------------
module lpcp_coef_table (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [4:0]           i_wr_index,
    input  lpcp_pkg::t_coef      i_wr_value,
    output lpcp_pkg::t_coef      o_coef [lpcp_pkg::CoefCount]
);

    lpcp_pkg::t_coef r_coef [lpcp_pkg::CoefCount];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lpcp_pkg::CoefCount; i++) r_coef[i] <= '0;
        end else if (i_wr) begin
            for (int i = 0; i < lpcp_pkg::CoefCount; i++) begin
                if (i_wr_index == 5'(i)) r_coef[i] <= i_wr_value;
            end
        end
    end

    assign o_coef = r_coef;

endmodule

// ===== rtl/core/lpcp_row_mac.sv =====
// ----------------------------------------------------------------------------
// lpcp_row_mac
// One matrix row times the homogeneous point, three register stages.
// ----------------------------------------------------------------------------
module lpcp_row_mac #(
    parameter int POINT_FRAC_BITS = lpcp_pkg::PointFracBits
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  lpcp_pkg::t_coef  i_coef [4],
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic signed [31:0] i_z,
    output lpcp_pkg::t_sum   o_sum
);

    lpcp_pkg::t_sum  r_prod [3];
    lpcp_pkg::t_coef r_c3;
    lpcp_pkg::t_sum  r_p01;
    lpcp_pkg::t_sum  r_p23;
    lpcp_pkg::t_sum  r_sum;
    lpcp_pkg::t_sum  n_c3;

    assign n_c3 = $signed({{32{r_c3[31]}}, r_c3}) <<< POINT_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod[0] <= i_coef[0] * i_x;
            r_prod[1] <= i_coef[1] * i_y;
            r_prod[2] <= i_coef[2] * i_z;
            r_c3      <= i_coef[3];
            r_p01     <= (r_prod[0] >>> 2) + (r_prod[1] >>> 2);
            r_p23     <= (r_prod[2] >>> 2) + (n_c3 >>> 2);
            r_sum     <= r_p01 + r_p23;
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== rtl/core/lpcp_div_stage.sv =====
// ----------------------------------------------------------------------------
// lpcp_div_stage
// One restoring division step, one quotient bit.
// ----------------------------------------------------------------------------
module lpcp_div_stage #(
    parameter int BIT = 0
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  lpcp_pkg::t_div_lane i_lane,
    output lpcp_pkg::t_div_lane o_lane
);

    localparam int TW = 64 + lpcp_pkg::QuoBits;

    logic [TW-1:0]       trial;
    lpcp_pkg::t_div_lane n_lane;
    lpcp_pkg::t_div_lane r_lane;

    assign trial = {{lpcp_pkg::QuoBits{1'b0}}, i_lane.den} << BIT;

    always_comb begin
        n_lane = i_lane;
        if ({{lpcp_pkg::QuoBits{1'b0}}, i_lane.rem} >= trial) begin
            n_lane.rem      = i_lane.rem - trial[63:0];
            n_lane.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_lane <= n_lane;
    end

    assign o_lane = r_lane;

endmodule

// ===== rtl/core/lidar_point_camera_projection.sv =====
// ----------------------------------------------------------------------------
// lidar_point_camera_projection
// Projects lidar points to camera pixels and transforms them to world frame.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall. A beat with command load writes one
// coefficient (index 0-11 projection, 12-23 world) and yields no result; a
// beat with command point yields exactly one result beat on o_out_valid /
// i_out_stall, in order.
// Configuration: i_cfg_valid / o_cfg_ready (always ready), index 0 width,
// index 1 height; write only while the pipeline is empty.
// From point beat to result beat there are three stages of row
// multiply-accumulate, one of saturation and bound products, one of bound
// compare, twelve of restoring division, one quotient bit per stage.
// Throughput is one beat per cycle while the receiver does not stall.
// Reset clears the coefficients to zero, restores width 1242 and height 375
// and empties the pipeline. While the receiver stalls with a result waiting,
// the whole pipeline holds and o_in_stall is raised; nothing is dropped.
// ----------------------------------------------------------------------------
module lidar_point_camera_projection #(
    parameter int COEF_FRAC_BITS  = lpcp_pkg::CoefFracBits,
    parameter int POINT_FRAC_BITS = lpcp_pkg::PointFracBits
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_command,
    input  logic [4:0]         i_coef_index,
    input  logic signed [31:0] i_coef_value,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [11:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_point_valid,
    output logic signed [31:0] o_world_x,
    output logic signed [31:0] o_world_y,
    output logic signed [31:0] o_world_z,
    output logic [11:0]        o_pixel_col,
    output logic [11:0]        o_pixel_row
);

    localparam int NDIV = lpcp_pkg::QuoBits;

    logic en;
    logic accept;
    logic r_out_vld;

    logic [11:0] r_width;
    logic [11:0] r_height;

    lpcp_pkg::t_coef coef [lpcp_pkg::CoefCount];
    lpcp_pkg::t_sum  row_sum [6];

    logic [2:0] r_mv;
    logic       r_v4;
    logic       r_v5;
    logic [NDIV-1:0] r_dv;

    lpcp_pkg::t_sum     r4_cx, r4_cy, r4_cz;
    logic signed [77:0] r4_tw, r4_th;
    logic signed [31:0] r4_world [3];
    logic signed [31:0] n4_world [3];
    lpcp_pkg::t_sum     wshift [3];

    logic               r5_ok;
    logic signed [31:0] r5_world [3];
    lpcp_pkg::t_div_lane r5_col, r5_row;

    lpcp_pkg::t_div_lane col_lane [NDIV+1];
    lpcp_pkg::t_div_lane row_lane [NDIV+1];
    logic               r_dok [NDIV];
    logic signed [31:0] r_dworld [NDIV][3];

    logic signed [13:0] lim_w, lim_h;
    logic               n5_ok;

    assign en          = !(r_out_vld && i_out_stall);
    assign o_in_stall  = !en;
    assign accept      = i_in_valid && en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= lpcp_pkg::WidthReset;
            r_height <= lpcp_pkg::HeightReset;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == lpcp_pkg::RegWidth)  r_width  <= i_cfg_data;
            if (i_cfg_index == lpcp_pkg::RegHeight) r_height <= i_cfg_data;
        end
    end

    lpcp_coef_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (accept && i_command == lpcp_pkg::CmdLoad),
        .i_wr_index (i_coef_index),
        .i_wr_value (i_coef_value),
        .o_coef     (coef)
    );

    for (genvar r = 0; r < 6; r++) begin : g_row
        localparam int BASE = (r < 3) ? 4 * r : lpcp_pkg::WorldBase + 4 * (r - 3);
        lpcp_pkg::t_coef row_coef [4];
        assign row_coef[0] = coef[BASE];
        assign row_coef[1] = coef[BASE + 1];
        assign row_coef[2] = coef[BASE + 2];
        assign row_coef[3] = coef[BASE + 3];
        lpcp_row_mac #(.POINT_FRAC_BITS(POINT_FRAC_BITS)) u_mac (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_coef (row_coef),
            .i_x    (i_point_x),
            .i_y    (i_point_y),
            .i_z    (i_point_z),
            .o_sum  (row_sum[r])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= '0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_dv <= '0;
        end else if (en) begin
            r_mv <= {r_mv[1:0], i_in_valid && i_command == lpcp_pkg::CmdPoint};
            r_v4 <= r_mv[2];
            r_v5 <= r_v4;
            r_dv <= {r_dv[NDIV-2:0], r_v5};
        end
    end

    assign lim_w = $signed({1'b0, r_width, 1'b0}) - 14'sd1;
    assign lim_h = $signed({1'b0, r_height, 1'b0}) - 14'sd1;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            wshift[k] = row_sum[3 + k] >>> (COEF_FRAC_BITS - 2);
            if (wshift[k] > 64'sh7FFF_FFFF)
                n4_world[k] = 32'sh7FFF_FFFF;
            else if (wshift[k] < -64'sh8000_0000)
                n4_world[k] = -32'sh8000_0000;
            else
                n4_world[k] = wshift[k][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_cx    <= row_sum[0];
            r4_cy    <= row_sum[1];
            r4_cz    <= row_sum[2];
            r4_tw    <= row_sum[2] * lim_w;
            r4_th    <= row_sum[2] * lim_h;
            r4_world <= n4_world;
        end
    end

    assign n5_ok = (r4_cz > 0) && (r4_cx > 0) && (r4_cy > 0)
                && (r_width != 12'd0) && (r_height != 12'd0)
                && ($signed({{13{r4_cx[63]}}, r4_cx, 1'b0}) < r4_tw)
                && ($signed({{13{r4_cy[63]}}, r4_cy, 1'b0}) < r4_th);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_ok        <= n5_ok;
            r5_world     <= r4_world;
            r5_col.rem   <= r4_cx;
            r5_col.den   <= r4_cz;
            r5_col.quo   <= '0;
            r5_row.rem   <= r4_cy;
            r5_row.den   <= r4_cz;
            r5_row.quo   <= '0;
        end
    end

    assign col_lane[0] = r5_col;
    assign row_lane[0] = r5_row;

    for (genvar s = 0; s < NDIV; s++) begin : g_div
        lpcp_div_stage #(.BIT(NDIV - 1 - s)) u_col (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_lane (col_lane[s]),
            .o_lane (col_lane[s + 1])
        );
        lpcp_div_stage #(.BIT(NDIV - 1 - s)) u_row (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_lane (row_lane[s]),
            .o_lane (row_lane[s + 1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dok[0]    <= r5_ok;
            r_dworld[0] <= r5_world;
            for (int s = 1; s < NDIV; s++) begin
                r_dok[s]    <= r_dok[s - 1];
                r_dworld[s] <= r_dworld[s - 1];
            end
        end
    end

    assign r_out_vld     = r_dv[NDIV-1];
    assign o_out_valid   = r_out_vld;
    assign o_point_valid = r_dok[NDIV-1];
    assign o_world_x     = r_dworld[NDIV-1][0];
    assign o_world_y     = r_dworld[NDIV-1][1];
    assign o_world_z     = r_dworld[NDIV-1][2];
    assign o_pixel_col   = r_dok[NDIV-1] ? col_lane[NDIV].quo : 12'd0;
    assign o_pixel_row   = r_dok[NDIV-1] ? row_lane[NDIV].quo : 12'd0;

endmodule

// ===== sim/lidar_point_camera_projection_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lidar_point_camera_projection_checker
// Watches the input, configuration and result channels of the projection
// block, keeps its own copy of the coefficient table and image size, predicts
// each point result and compares it field by field with the result beats.
// ----------------------------------------------------------------------------
module lidar_point_camera_projection_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_command,
    input  logic [4:0]         i_coef_index,
    input  logic signed [31:0] i_coef_value,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [11:0]        i_cfg_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_point_valid,
    input  logic signed [31:0] i_world_x,
    input  logic signed [31:0] i_world_y,
    input  logic signed [31:0] i_world_z,
    input  logic [11:0]        i_pixel_col,
    input  logic [11:0]        i_pixel_row,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct {
        logic               on_image;
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
        logic [11:0]        col;
        logic [11:0]        row;
    } t_projection;

    logic signed [31:0] coef_tab [lpcp_pkg::CoefCount];
    logic [11:0]        img_width;
    logic [11:0]        img_height;
    t_projection        projections_due [$];

    assign o_pending = projections_due.size();

    function automatic longint row_acc(int base, int r, longint px, longint py, longint pz);
        longint acc;
        acc = (longint'(coef_tab[base + 4*r]) * px) >>> 2;
        acc += (longint'(coef_tab[base + 4*r + 1]) * py) >>> 2;
        acc += (longint'(coef_tab[base + 4*r + 2]) * pz) >>> 2;
        acc += (longint'(coef_tab[base + 4*r + 3]) *
                (longint'(1) <<< lpcp_pkg::PointFracBits)) >>> 2;
        return acc;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
        if (v < -longint'(64'd2147483648)) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic bit fits_bound(longint num, longint den, logic [11:0] lim,
                                      output logic [11:0] q);
        longint unsigned quo;
        longint unsigned rem;
        q = '0;
        if (num <= 0 || lim == 0) return 0;
        quo = longint'(num) / den;
        rem = longint'(num) % den;
        q = quo[11:0];
        if (quo < longint'(lim) - 1) return 1;
        return quo == longint'(lim) - 1 && 2 * rem < den;
    endfunction

    function automatic t_projection project_point(longint px, longint py, longint pz);
        t_projection p;
        longint cx, cy, cz;
        logic [11:0] qc, qr;
        bit ok;
        cx = row_acc(0, 0, px, py, pz);
        cy = row_acc(0, 1, px, py, pz);
        cz = row_acc(0, 2, px, py, pz);
        p.wx = clamp32(row_acc(lpcp_pkg::WorldBase, 0, px, py, pz)
                       >>> (lpcp_pkg::CoefFracBits - 2));
        p.wy = clamp32(row_acc(lpcp_pkg::WorldBase, 1, px, py, pz)
                       >>> (lpcp_pkg::CoefFracBits - 2));
        p.wz = clamp32(row_acc(lpcp_pkg::WorldBase, 2, px, py, pz)
                       >>> (lpcp_pkg::CoefFracBits - 2));
        ok = 0;
        qc = '0;
        qr = '0;
        if (cz > 0)
            ok = fits_bound(cx, cz, img_width, qc) && fits_bound(cy, cz, img_height, qr);
        p.on_image = ok;
        p.col = ok ? qc : 12'd0;
        p.row = ok ? qr : 12'd0;
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_projection e;
        if (!i_rst_n) begin
            foreach (coef_tab[k]) coef_tab[k] = '0;
            img_width = lpcp_pkg::WidthReset;
            img_height = lpcp_pkg::HeightReset;
            projections_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (projections_due.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    o_fail_count++;
                end else begin
                    e = projections_due.pop_front();
                    if (e.on_image !== i_point_valid || e.wx !== i_world_x ||
                        e.wy !== i_world_y || e.wz !== i_world_z ||
                        e.col !== i_pixel_col || e.row !== i_pixel_row) begin
                        $display("%0t: mismatch expected v=%0d w=(%0d,%0d,%0d) px=(%0d,%0d)",
                                 $time, e.on_image, e.wx, e.wy, e.wz, e.col, e.row);
                        $display("%0t:          actual   v=%0d w=(%0d,%0d,%0d) px=(%0d,%0d)",
                                 $time, i_point_valid, i_world_x, i_world_y, i_world_z,
                                 i_pixel_col, i_pixel_row);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_command == lpcp_pkg::CmdLoad) begin
                    if (i_coef_index < lpcp_pkg::CoefCount)
                        coef_tab[i_coef_index] = i_coef_value;
                end else begin
                    e = project_point(i_point_x, i_point_y, i_point_z);
                    projections_due.insert(projections_due.size(), e);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == lpcp_pkg::RegWidth) img_width = i_cfg_data;
                else if (i_cfg_index == lpcp_pkg::RegHeight) img_height = i_cfg_data;
            end
        end
    end
endmodule

// ===== sim/tb_lidar_point_camera_projection.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lidar_point_camera_projection
// Drives coefficient loads and lidar points into the projection block in
// bursts under random result stalls, across several image sizes including
// the extremes; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_lidar_point_camera_projection;

    localparam int CycleLimit = 300000;
    localparam int DrainCycles = 24;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_command = lpcp_pkg::CmdLoad;
    logic [4:0]         i_coef_index = '0;
    logic signed [31:0] i_coef_value = '0;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_y = '0;
    logic signed [31:0] i_point_z = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [11:0]        i_cfg_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_point_valid;
    logic signed [31:0] o_world_x, o_world_y, o_world_z;
    logic [11:0]        o_pixel_col, o_pixel_row;
    int                 fail_count, pending;
    int                 cycles = 0;
    int                 burst_left = 0;
    int                 stall_mode = 0;
    logic [11:0]        cur_w = lpcp_pkg::WidthReset;
    logic [11:0]        cur_h = lpcp_pkg::HeightReset;
    int                 focal = 1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    lidar_point_camera_projection dut (.*);

    lidar_point_camera_projection_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_command,
        .i_coef_index, .i_coef_value, .i_point_x, .i_point_y, .i_point_z,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_out_valid(o_out_valid), .i_out_stall, .i_point_valid(o_point_valid),
        .i_world_x(o_world_x), .i_world_y(o_world_y), .i_world_z(o_world_z),
        .i_pixel_col(o_pixel_col), .i_pixel_row(o_pixel_row),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver stall pattern: a randomly picked mode of no, light or heavy stalls
    always @(negedge i_clk) begin
        if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            default: i_out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    task automatic beat(logic cmd, logic [4:0] idx, logic signed [31:0] val,
                        logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
        if (burst_left == 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end else begin
            @(negedge i_clk);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_coef_index <= idx;
        i_coef_value <= val;
        i_point_x <= x;
        i_point_y <= y;
        i_point_z <= z;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic load(int idx, logic signed [31:0] val);
        beat(lpcp_pkg::CmdLoad, 5'(idx), val, $urandom, $urandom, $urandom);
    endtask

    task automatic point(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
        beat(lpcp_pkg::CmdPoint, 5'($urandom), $urandom, x, y, z);
    endtask

    // hold off until every result is in, then let the pipeline empty
    task automatic settle();
        @(negedge i_clk) i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [11:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
        if (idx == lpcp_pkg::RegWidth) cur_w = data;
        else if (idx == lpcp_pkg::RegHeight) cur_h = data;
    endtask

    task automatic set_camera();
        int cu, cv;
        focal = $urandom_range(50, 600);
        cu = (cur_w == 0) ? 1 : cur_w / 2;
        cv = (cur_h == 0) ? 1 : cur_h / 2;
        load(0, focal <<< lpcp_pkg::CoefFracBits);
        load(1, 0);
        load(2, cu <<< lpcp_pkg::CoefFracBits);
        load(3, $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 1 << 22)) : 0);
        load(5, focal <<< lpcp_pkg::CoefFracBits);
        load(6, cv <<< lpcp_pkg::CoefFracBits);
        load(10, 1 <<< lpcp_pkg::CoefFracBits);
        for (int k = lpcp_pkg::WorldBase; k < lpcp_pkg::CoefCount; k++)
            load(k, (k % 4 == 3) ? int'($urandom) >>> 4
                                 : int'($urandom_range(0, 2 << lpcp_pkg::CoefFracBits))
                                   - (1 << lpcp_pkg::CoefFracBits));
    endtask

    task automatic random_item();
        int r, cu, cv;
        longint z, x, y;
        r = $urandom_range(0, 99);
        cu = (cur_w == 0) ? 1 : cur_w / 2;
        cv = (cur_h == 0) ? 1 : cur_h / 2;
        if (r < 3) begin
            load($urandom_range(0, 23), $urandom);
        end else if (r < 6) begin
            load($urandom_range(24, 31), $urandom);
        end else if (r < 8) begin
            set_camera();
        end else if (r < 22) begin
            point($urandom, $urandom, $urandom);
        end else begin
            z = $urandom_range(1 << 15, 60 << 16);
            x = z * (longint'($urandom_range(0, 2 * cu + 4)) - cu - 2) / focal;
            y = z * (longint'($urandom_range(0, 2 * cv + 4)) - cv - 2) / focal;
            point(32'(x), 32'(y), 32'(z));
        end
    endtask

    initial begin
        logic [11:0] widths [6];
        logic [11:0] heights [6];
        widths = '{lpcp_pkg::WidthReset, 12'd4095, 12'd1, 12'd0, 12'd640, 12'd0};
        heights = '{lpcp_pkg::HeightReset, 12'd4095, 12'd1, 12'd7, 12'd0, 12'd0};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // identity camera, world matrix at the coefficient extremes
        load(0, 1 <<< lpcp_pkg::CoefFracBits);
        load(5, 1 <<< lpcp_pkg::CoefFracBits);
        load(10, 1 <<< lpcp_pkg::CoefFracBits);
        load(12, 32'sh7fffffff);
        load(13, 32'sh80000000);
        load(19, 32'sh7fffffff);
        load(31, 32'sh12345678);
        point((2 * 1242 - 1) <<< 16, 2 <<< 16, 2 <<< 16);
        point(((2 * 1242 - 1) <<< 16) - 1, 2 <<< 16, 2 <<< 16);
        point(2 <<< 16, (2 * 375 - 1) <<< 16, 2 <<< 16);
        point(2 <<< 16, ((2 * 375 - 1) <<< 16) - 1, 2 <<< 16);
        point(0, 2 <<< 16, 2 <<< 16);
        point(2 <<< 16, 2 <<< 16, 0);
        point(2 <<< 16, 2 <<< 16, -(2 <<< 16));
        point(32'sh7fffffff, 32'sh80000000, 1);
        point(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
        point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        point(32'sh80000000, 32'sh80000000, 32'sh80000000);
        settle();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                write_reg(lpcp_pkg::RegWidth, ph == 5 ? 12'($urandom) : widths[ph]);
                write_reg(lpcp_pkg::RegHeight, ph == 5 ? 12'($urandom) : heights[ph]);
                write_reg(2'($urandom_range(2, 3)), 12'($urandom));
            end
            set_camera();
            for (int n = 0; n < 42; n++) random_item();
            settle();
        end

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
